### hw/rtl/gamma_scaled_step_sequencer_defines.svh
// Assertion macros shared by the sequencer RTL.
`ifndef GAMMA_SCALED_STEP_SEQUENCER_DEFINES_SVH
`define GAMMA_SCALED_STEP_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at each rising clock edge while reset is released.
`define GSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked at every rising clock edge, reset included.
`define GSS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GSS_ASSERT(label, clk, rst_n, prop, msg)
`define GSS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### hw/rtl/gss_pkg.sv
package gss_pkg;

    // Field widths of one input transaction and one result transaction.
    localparam int RATE_W  = 24;
    localparam int NOTE_W  = 7;
    localparam int STEP_W  = 4;
    localparam int PLEN_W  = 5;
    localparam int SLEN_W  = 34;
    localparam int ACC_W   = 40;

    // Step length after reset: 6000 samples in Q16.
    localparam logic [SLEN_W-1:0] STEP_LEN_RESET = 34'd393216000;

    // Rate 1.0 in Q8.16 and the near-zero band of a master rate.
    localparam logic signed [RATE_W-1:0] ONE_Q16       = 24'sd65536;
    localparam logic signed [RATE_W-1:0] NEAR_ZERO_MAX = 24'sd6;

    // Command codes.
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_RESET = 2'd2,
        FUNC_LOAD  = 2'd3
    } t_func;

    typedef struct packed {
        t_func                     func;
        logic signed [RATE_W-1:0]  rate;
        logic                      rate_is_sample;
        logic [STEP_W-1:0]         entry_index;
        logic [NOTE_W-1:0]         entry_note;
    } t_in_item;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [STEP_W-1:0] step_index;
        logic              advanced;
    } t_out_item;

    // Note table contents after reset.
    function automatic logic [NOTE_W-1:0] default_note(input int idx);
        logic [NOTE_W-1:0] val;
        case (idx)
            0:       val = 7'd48;
            1:       val = 7'd55;
            2:       val = 7'd58;
            3:       val = 7'd60;
            4:       val = 7'd62;
            5:       val = 7'd65;
            6:       val = 7'd67;
            7:       val = 7'd70;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### hw/rtl/gss_stream_if.sv
// Valid/ready channel carrying one input transaction.
interface gss_in_if;
    import gss_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Valid/ready channel carrying one result transaction.
interface gss_out_if;
    import gss_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/gamma_scaled_step_sequencer.sv
// An accepted input transaction passes through the input register, then the result register;
// the step state is updated as the result is registered.
// Throughput: one transaction per cycle while o_out.ready holds; the result register frees the input side.
// Reset (synchronous, active low): step 0, accumulator 0, pattern length 8,
// default note table, step length 6000 samples, both pipeline registers empty.
`include "gamma_scaled_step_sequencer_defines.svh"

module gamma_scaled_step_sequencer #(
    parameter int NOTE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gss_pkg::SLEN_W-1:0]    i_cfg_wdata,
    gss_in_if.sink                        i_in,
    gss_out_if.source                     o_out
);
    import gss_pkg::*;

    // Only the first sixteen entries can be written or reached as a step.
    localparam int TBL_DEPTH = (NOTE_DEPTH < 16) ? NOTE_DEPTH : 16;
    localparam int IDX_W     = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int PLEN_RST  = (NOTE_DEPTH < 8) ? NOTE_DEPTH : 8;

    // Pipeline registers.
    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;

    // Sequencer state.
    logic [SLEN_W-1:0]       r_step_len;
    logic [NOTE_W-1:0]       r_notes [TBL_DEPTH];
    logic [PLEN_W-1:0]       r_plen;
    logic [STEP_W-1:0]       r_step;
    logic signed [ACC_W-1:0] r_acc;

    logic [NOTE_W-1:0]       n_notes [TBL_DEPTH];
    logic [PLEN_W-1:0]       n_plen;
    logic [STEP_W-1:0]       n_step;
    logic signed [ACC_W-1:0] n_acc;
    logic                    n_adv;

    logic out_free;
    logic s1_move;
    logic in_fire;

    logic signed [RATE_W-1:0] eff_rate;
    logic signed [ACC_W:0]    acc_sum;
    logic signed [ACC_W+1:0]  acc_diff;
    logic signed [ACC_W+1:0]  acc_sel;
    logic                     crossed;
    logic [PLEN_W-1:0]        step_inc;
    logic [STEP_W-1:0]        step_next;

    // Handshake: stage one moves whenever the result register is free.
    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_move     = r_s1_valid && out_free;
    assign i_in.ready  = !r_s1_valid || out_free;
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Step advance with wrap at the pattern length.
    always_comb begin
        step_inc  = {1'b0, r_step} + 5'd1;
        step_next = step_inc[STEP_W-1:0];
        if (step_inc >= r_plen || step_inc >= PLEN_W'(TBL_DEPTH)) begin
            step_next = '0;
        end
    end

    // Accumulator update for a sample tick, with one crossing at most.
    always_comb begin
        eff_rate = r_s1.rate;
        if (!r_s1.rate_is_sample && r_s1.rate >= -NEAR_ZERO_MAX
                && r_s1.rate <= NEAR_ZERO_MAX) begin
            eff_rate = ONE_Q16;
        end
        acc_sum  = (ACC_W+1)'(r_acc) + (ACC_W+1)'(eff_rate);
        acc_diff = (ACC_W+2)'(acc_sum) - $signed({8'd0, r_step_len});
        crossed  = !acc_diff[ACC_W+1];
        acc_sel  = crossed ? acc_diff : (ACC_W+2)'(acc_sum);
    end

    // Next state and result for the transaction in stage one.
    always_comb begin
        n_notes = r_notes;
        n_plen  = r_plen;
        n_step  = r_step;
        n_acc   = r_acc;
        n_adv   = 1'b0;
        case (r_s1.func)
            FUNC_TICK: begin
                if (crossed) begin
                    n_step = step_next;
                    n_adv  = 1'b1;
                end
                // Saturate when the top bits disagree with the sign.
                if (acc_sel[ACC_W+1:ACC_W-1] != {3{acc_sel[ACC_W+1]}}) begin
                    n_acc = acc_sel[ACC_W+1] ? {1'b1, {(ACC_W-1){1'b0}}}
                                             : {1'b0, {(ACC_W-1){1'b1}}};
                end else begin
                    n_acc = acc_sel[ACC_W-1:0];
                end
            end
            FUNC_STEP: begin
                n_step = step_next;
                n_adv  = 1'b1;
            end
            FUNC_RESET: begin
                n_step = '0;
                n_acc  = '0;
            end
            FUNC_LOAD: begin
                if (32'(r_s1.entry_index) < TBL_DEPTH) begin
                    n_notes[r_s1.entry_index[IDX_W-1:0]] = r_s1.entry_note;
                    n_plen = {1'b0, r_s1.entry_index} + 5'd1;
                    n_step = '0;
                    n_acc  = '0;
                end
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    // Control registers and sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_step_len  <= STEP_LEN_RESET;
            r_plen      <= PLEN_W'(PLEN_RST);
            r_step      <= '0;
            r_acc       <= '0;
            for (int i = 0; i < TBL_DEPTH; i++) begin
                r_notes[i] <= default_note(i);
            end
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_step_len <= i_cfg_wdata;
            end
            if (s1_move) begin
                r_notes <= n_notes;
                r_plen  <= n_plen;
                r_step  <= n_step;
                r_acc   <= n_acc;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in.data;
        end
        if (s1_move) begin
            r_out.note       <= n_notes[n_step[IDX_W-1:0]];
            r_out.step_index <= n_step;
            r_out.advanced   <= n_adv;
        end
    end

    // Assertions.
    `GSS_ASSERT(a_step_in_pattern, i_clk, i_rst_n, {1'b0, r_step} < r_plen, "step beyond pattern length")
    `GSS_ASSERT(a_plen_range, i_clk, i_rst_n, r_plen != '0 && r_plen <= PLEN_W'(TBL_DEPTH), "pattern length out of range")
    `GSS_ASSERT(a_reset_clears_acc, i_clk, i_rst_n, s1_move && r_s1.func == FUNC_RESET |=> r_acc == '0 && r_step == '0, "reset command left time or step")
    `GSS_ASSERT(a_no_adv_on_cmd, i_clk, i_rst_n, s1_move && (r_s1.func == FUNC_RESET || r_s1.func == FUNC_LOAD) |=> !r_out.advanced, "reset or load reported an advance")

endmodule
